>>> design/cctfr_pkg.sv
// Shared package for the CRC-checked telemetry frame receiver.
// Holds the frame layout constants, the status and register codes and the CRC-8 step.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cctfr_pkg;

   // Bytes in one frame: the payload bytes followed by one CRC byte.
   localparam int FRAME_LENGTH = 23;
   localparam int PAYLOAD_LEN  = FRAME_LENGTH - 1;
   localparam int INDEX_W      = $clog2(FRAME_LENGTH + 1);

   // Storage covers the highest payload offset that a field uses.
   localparam int STORE_DEPTH  = 22;
   localparam int STORE_W      = $clog2(STORE_DEPTH);

   localparam int OFS_VERSION  = 0;
   localparam int OFS_SERVICE  = 1;
   localparam int OFS_SETUP    = 5;
   localparam int OFS_RESETS   = 6;
   localparam int OFS_MODEL    = 7;
   localparam int OFS_KIND_A   = 8;
   localparam int OFS_KIND_B   = 9;
   localparam int OFS_PULSES_A = 10;
   localparam int OFS_PULSES_B = 14;
   localparam int OFS_LEVEL_A  = 18;
   localparam int OFS_LEVEL_B  = 20;

   localparam logic [7:0] CRC_POLY       = 8'h8C;
   localparam logic [7:0] SEED_RESET     = 8'hFF;
   localparam logic [7:0] MIN_VER_RESET  = 8'd30;
   localparam logic [7:0] LEGACY_RESET   = 8'd29;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_READ_FAIL   = 2'd1,
      STATUS_CRC_BAD     = 2'd2,
      STATUS_OLD_VERSION = 2'd3
   } status_type;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_DATA  = 1'b1
   } cmd_type;

   typedef enum logic {
      REG_MIN_VERSION = 1'b0,
      REG_LEGACY_LIM  = 1'b1
   } csr_reg_type;

   // One byte of the reflected CRC-8, least significant bit first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic [7:0] d;
      logic       fb;
      c = crc;
      d = data;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ d[0];
         c  = {1'b0, c[7:1]};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
         d = {1'b0, d[7:1]};
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> design/crc_checked_telemetry_frame_receiver.sv
// Top level of the CRC-checked telemetry frame receiver.
// Depends on cctfr_pkg for the frame layout, codes and the CRC-8 step.
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction per clock when not stalled: a start command or one received frame byte.
// Each payload byte read without error updates the CRC and the payload store in the
// cycle it is accepted, and the CRC byte of a frame loads the result register, so the
// result appears in the cycle after the last byte. The input stalls only when the
// CRC byte of a frame arrives while the previous result is still waiting in the result
// register because the result channel is stalled in that cycle.
// A version byte below the legacy limit clears the CRC seed until the next reset.
module crc_checked_telemetry_frame_receiver
   import cctfr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_cmd,
   input  wire logic [7:0]             req_rx_byte,
   input  wire logic                   req_read_ok,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [7:0]                  rsp_version,
   output logic [7:0]                  rsp_service_code,
   output logic [7:0]                  rsp_setup_count,
   output logic [7:0]                  rsp_reset_count,
   output logic [7:0]                  rsp_model_code,
   output logic [7:0]                  rsp_kind_a,
   output logic [7:0]                  rsp_kind_b,
   output logic [31:0]                 rsp_pulses_a,
   output logic [31:0]                 rsp_pulses_b,
   output logic [15:0]                 rsp_level_a,
   output logic [15:0]                 rsp_level_b,

   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(FRAME_LENGTH - 1);
   localparam logic [INDEX_W-1:0] DONE_IDX = INDEX_W'(FRAME_LENGTH);

   logic [7:0]         min_ver_ff, min_ver_in;
   logic [7:0]         legacy_ff, legacy_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [7:0]         crc_ff, crc_in;
   logic [7:0]         seed_ff, seed_in;
   logic               good_ff, good_in;
   logic               out_valid_ff, out_valid_in;

   logic [7:0]         frame_ff [STORE_DEPTH];
   logic               store_we;

   status_type         status_ff, status_in;
   logic [7:0]         version_ff, service_ff, setup_ff, resets_ff, model_ff;
   logic [7:0]         kind_a_ff, kind_b_ff;
   logic [31:0]        pulses_a_ff, pulses_b_ff;
   logic [15:0]        level_a_ff, level_b_ff;

   logic               accept;
   logic               is_last;
   logic               load_result;
   logic               csr_write;
   logic [7:0]         crc_base;
   logic [7:0]         payload [STORE_DEPTH];

   // ------------------------------------------------------------------
   // Configuration port.
   // ------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      min_ver_in = min_ver_ff;
      legacy_in  = legacy_ff;
      if (csr_write) begin
         unique case (csr_reg_type'(csr_paddr[2]))
            REG_MIN_VERSION: min_ver_in = csr_pwdata[7:0];
            REG_LEGACY_LIM:  legacy_in  = csr_pwdata[7:0];
            default:         min_ver_in = min_ver_ff;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_reg_type'(csr_paddr[2]))
         REG_MIN_VERSION: csr_prdata[7:0] = min_ver_ff;
         REG_LEGACY_LIM:  csr_prdata[7:0] = legacy_ff;
         default:         csr_prdata      = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Handshake.
   // ------------------------------------------------------------------
   assign is_last   = (index_ff == LAST_IDX);
   assign req_stall = out_valid_ff & rsp_stall & req_cmd & is_last;
   assign accept    = req_valid & ~req_stall;

   // Payload bytes as the fields see them; offsets past the payload read as zero.
   always_comb begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
         payload[k] = (k < PAYLOAD_LEN) ? frame_ff[k] : 8'h00;
      end
   end

   // ------------------------------------------------------------------
   // Frame state.
   // ------------------------------------------------------------------
   always_comb begin
      index_in     = index_ff;
      crc_in       = crc_ff;
      seed_in      = seed_ff;
      good_in      = good_ff;
      store_we     = 1'b0;
      load_result  = 1'b0;
      status_in    = STATUS_OK;
      out_valid_in = out_valid_ff & rsp_stall;

      // The first payload byte starts from the stored seed, or from zero when it is a version below the legacy limit.
      crc_base = (index_ff == '0) ? seed_ff : crc_ff;

      if (accept) begin
         if (cmd_type'(req_cmd) == CMD_START) begin
            index_in = '0;
            crc_in   = seed_ff;
            good_in  = 1'b1;
         end else if (index_ff < LAST_IDX) begin
            if (req_read_ok) begin
               store_we = (index_ff < INDEX_W'(STORE_DEPTH));
               if (index_ff == INDEX_W'(OFS_VERSION) && req_rx_byte < legacy_ff) begin
                  seed_in  = 8'h00;
                  crc_base = 8'h00;
               end
               crc_in = crc8_byte(crc_base, req_rx_byte);
            end else begin
               good_in = 1'b0;
               crc_in  = crc_base;
            end
            index_in = index_ff + INDEX_W'(1);
         end else if (is_last) begin
            index_in     = DONE_IDX;
            good_in      = good_ff & req_read_ok;
            load_result  = 1'b1;
            out_valid_in = 1'b1;
            if (!(good_ff & req_read_ok)) begin
               status_in = STATUS_READ_FAIL;
            end else if (req_rx_byte != crc_ff) begin
               status_in = STATUS_CRC_BAD;
            end else if (payload[OFS_VERSION] < min_ver_ff) begin
               status_in = STATUS_OLD_VERSION;
            end else begin
               status_in = STATUS_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ver_ff   <= MIN_VER_RESET;
         legacy_ff    <= LEGACY_RESET;
         index_ff     <= '0;
         crc_ff       <= 8'h00;
         seed_ff      <= SEED_RESET;
         good_ff      <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         min_ver_ff   <= min_ver_in;
         legacy_ff    <= legacy_in;
         index_ff     <= index_in;
         crc_ff       <= crc_in;
         seed_ff      <= seed_in;
         good_ff      <= good_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload store; entries are only meaningful once written.
   always_ff @(posedge clock) begin
      if (store_we) begin
         frame_ff[index_ff[STORE_W-1:0]] <= req_rx_byte;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load_result) begin
         status_ff   <= status_in;
         version_ff  <= payload[OFS_VERSION];
         service_ff  <= payload[OFS_SERVICE];
         setup_ff    <= payload[OFS_SETUP];
         resets_ff   <= payload[OFS_RESETS];
         model_ff    <= payload[OFS_MODEL];
         kind_a_ff   <= payload[OFS_KIND_A];
         kind_b_ff   <= payload[OFS_KIND_B];
         pulses_a_ff <= {payload[OFS_PULSES_A+3], payload[OFS_PULSES_A+2],
                         payload[OFS_PULSES_A+1], payload[OFS_PULSES_A]};
         pulses_b_ff <= {payload[OFS_PULSES_B+3], payload[OFS_PULSES_B+2],
                         payload[OFS_PULSES_B+1], payload[OFS_PULSES_B]};
         level_a_ff  <= {payload[OFS_LEVEL_A+1], payload[OFS_LEVEL_A]};
         level_b_ff  <= {payload[OFS_LEVEL_B+1], payload[OFS_LEVEL_B]};
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_version      = version_ff;
   assign rsp_service_code = service_ff;
   assign rsp_setup_count  = setup_ff;
   assign rsp_reset_count  = resets_ff;
   assign rsp_model_code   = model_ff;
   assign rsp_kind_a       = kind_a_ff;
   assign rsp_kind_b       = kind_b_ff;
   assign rsp_pulses_a     = pulses_a_ff;
   assign rsp_pulses_b     = pulses_b_ff;
   assign rsp_level_a      = level_a_ff;
   assign rsp_level_b      = level_b_ff;

endmodule

`default_nettype wire

>>> design/cctfr_checker.sv
// Port-level checker for the CRC-checked telemetry frame receiver.
// Depends on the top level's ports only; bound to the top level at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module cctfr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic req_cmd,
   input wire logic rsp_valid,
   input wire logic rsp_stall
);

   logic req_take;
   assign req_take = req_valid & ~req_stall;

   // A result is never dropped while the result channel stalls it.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A new result only follows an accepted data byte.
   a_rsp_from_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && rsp_stall) && !$past(reset)
         |-> $past(req_take && req_cmd))
      else $error("result without a data transaction");

   // A start command never produces a result.
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      req_take && !req_cmd && !(rsp_valid && rsp_stall) |=> !rsp_valid)
      else $error("start transaction produced a result");

endmodule

bind crc_checked_telemetry_frame_receiver cctfr_checker u_cctfr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_cmd   (req_cmd),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

`default_nettype wire
